/* src/ast_pkg.sv */
// ----------------------------------------------------------------------------
// ast_pkg
// types and constants used by the aging server table
// ----------------------------------------------------------------------------
package ast_pkg;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_REPLY = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_SEND  = 2'd3;

    // result status codes
    localparam logic [2:0] STS_DONE     = 3'd0;
    localparam logic [2:0] STS_STORED   = 3'd1;
    localparam logic [2:0] STS_MISMATCH = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_EMPTY    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCAL_APP_ID   = 2'd0;
    localparam logic [1:0] CFG_ENTRY_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_REQ_INTERVAL   = 2'd2;

    localparam int          CFG_IDX_W         = 2;
    localparam int          CFG_DATA_W        = 32;
    localparam int          COUNT_W           = 5;
    localparam int          QUERY_W           = 4;
    localparam logic [31:0] APP_MASK          = 32'hFFFF_FF00;
    localparam logic [15:0] REQ_INTERVAL_RST  = 16'd1000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] delta_ms;
        logic [47:0] from_addr;
        logic [31:0] reply_app_id;
        logic [31:0] sent_time_ms;
        logic [3:0]  query_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] entry_addr;
        logic [31:0] entry_ping_ms;
        logic        entry_wrong_version;
        logic [31:0] entry_time_left_ms;
        logic        request_granted;
        logic [31:0] now_ms;
        logic [4:0]  entry_count;
    } t_out_word;

    // one stored table entry
    typedef struct packed {
        logic [47:0] addr;
        logic [31:0] time_left;
        logic [31:0] ping;
        logic        wrong_version;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* src/ast_ram.sv */
// ----------------------------------------------------------------------------
// ast_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ast_sub.sv */
// ----------------------------------------------------------------------------
// ast_sub
// shared 32-bit subtract and compare unit
// ----------------------------------------------------------------------------
module ast_sub (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_le
);

    logic [32:0] w_full;

    // borrow out means a below b, zero difference means equal
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[31:0];
    assign o_le   = w_full[32] | (w_full[31:0] == 32'd0);

endmodule

/* src/aging_server_table.sv */
// ----------------------------------------------------------------------------
// aging_server_table
// ordered table of discovered servers with lifetime aging and request holdoff
// ----------------------------------------------------------------------------
// usage
//   input channel i_in_valid / o_in_stall carries one word per request: tick,
//   reply received, query by position or send check. output channel
//   o_out_valid / i_out_stall returns exactly one word per request.
//   configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
//   to be written only while the block is idle; the block does not enforce it.
// sequencing
//   tick: one table walk that reads each entry from the ram, ages it in the
//   shared subtract unit and writes kept entries back compacted
//   reply: an address search over the ram then one write
//   query: one ram read at the queried position; send check, mismatched
//   reply and out-of-range query go straight to the result word
//   the ram has a single read port and the subtract unit is shared;
//   one request is in flight at a time and o_in_stall is high meanwhile
// reset
//   synchronous active low: clock, holdoff and entry count go to zero,
//   configuration registers to their defaults; table contents are not cleared
// stall
//   a finished word waits in the output register; the block takes the next
//   request while it waits, and holds a later result until the register frees
// ----------------------------------------------------------------------------
module aging_server_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ast_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ast_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [ast_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ast_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IW  = $clog2(TABLE_DEPTH);      // ram address width
    localparam int CW  = $clog2(TABLE_DEPTH + 1);  // count width
    localparam int QCW = (CW > ast_pkg::QUERY_W) ? CW : ast_pkg::QUERY_W;

    // one-hot sequencer
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TK_RD = 9'b000000010,
        S_TK_EV = 9'b000000100,
        S_RP_RD = 9'b000001000,
        S_RP_EV = 9'b000010000,
        S_RP_WR = 9'b000100000,
        S_QY_RD = 9'b001000000,
        S_QY_EV = 9'b010000000,
        S_RESP  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;

    // configuration
    logic [31:0]         r_local_app_id;
    logic [31:0]         r_entry_timeout;
    logic [15:0]         r_req_interval;

    // block state
    logic [31:0]         r_clock, n_clock;
    logic [15:0]         r_holdoff, n_holdoff;
    logic [CW-1:0]       r_used, n_used;
    logic [CW-1:0]       r_rd, n_rd;        // walk / search position
    logic [CW-1:0]       r_wr, n_wr;        // compaction write position
    ast_pkg::t_in_word   r_item, n_item;
    ast_pkg::t_out_word  r_res, n_res;      // result under construction
    ast_pkg::t_out_word  r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // ram side
    logic                w_we, w_re;
    logic [IW-1:0]       w_waddr, w_raddr;
    ast_pkg::t_entry     w_wdata, w_rdata;
    logic [ast_pkg::ENTRY_W-1:0] w_rdata_bits;

    // shared subtract unit
    logic [31:0]         w_sub_a, w_sub_b, w_sub_diff;
    logic                w_sub_le;

    // misc decode
    logic                w_accept;
    logic                w_app_match;
    logic                w_query_hit;
    logic [QCW-1:0]      w_query_ext;
    logic                w_out_free;
    logic                w_keep;

    ast_ram #(
        .WIDTH (ast_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_bits)
    );

    assign w_rdata = ast_pkg::t_entry'(w_rdata_bits);

    ast_sub u_sub (
        .i_a    (w_sub_a),
        .i_b    (w_sub_b),
        .o_diff (w_sub_diff),
        .o_le   (w_sub_le)
    );

    // aging during the walk, ping during the reply write
    always_comb begin
        if (r_state == S_TK_EV) begin
            w_sub_a = w_rdata.time_left;
            w_sub_b = {16'd0, r_item.delta_ms};
        end else begin
            w_sub_a = r_clock;
            w_sub_b = r_item.sent_time_ms;
        end
    end

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_app_match = ((i_in_word.reply_app_id & ast_pkg::APP_MASK) ==
                          (r_local_app_id & ast_pkg::APP_MASK));
    assign w_query_ext = QCW'(i_in_word.query_index);
    assign w_query_hit = (w_query_ext < QCW'(r_used));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // lifetime zero never ages; otherwise kept only if above delta
    assign w_keep      = (w_rdata.time_left == 32'd0) || !w_sub_le;

    always_comb begin
        n_state     = r_state;
        n_clock     = r_clock;
        n_holdoff   = r_holdoff;
        n_used      = r_used;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        w_re    = 1'b0;
        w_raddr = r_rd[IW-1:0];
        w_we    = 1'b0;
        w_waddr = r_wr[IW-1:0];
        w_wdata = w_rdata;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item = i_in_word;
                    n_res  = '0;
                    n_rd   = '0;
                    n_wr   = '0;
                    case (i_in_word.req_type)
                        ast_pkg::REQ_TICK: begin
                            n_clock   = r_clock + {16'd0, i_in_word.delta_ms};
                            n_holdoff = (r_holdoff > i_in_word.delta_ms) ?
                                        (r_holdoff - i_in_word.delta_ms) : 16'd0;
                            n_state   = S_TK_RD;
                        end
                        ast_pkg::REQ_REPLY: begin
                            if (w_app_match) begin
                                n_state = S_RP_RD;
                            end else begin
                                n_res.status = ast_pkg::STS_MISMATCH;
                                n_state      = S_RESP;
                            end
                        end
                        ast_pkg::REQ_QUERY: begin
                            if (w_query_hit) begin
                                n_rd    = CW'(w_query_ext);
                                n_state = S_QY_RD;
                            end else begin
                                n_res.status = ast_pkg::STS_EMPTY;
                                n_state      = S_RESP;
                            end
                        end
                        default: begin
                            // send check
                            if (r_holdoff == 16'd0) begin
                                n_holdoff             = r_req_interval;
                                n_res.request_granted = 1'b1;
                            end
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_TK_RD: begin
                if (r_rd == r_used) begin
                    n_used  = r_wr;
                    n_state = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_TK_EV;
                end
            end

            S_TK_EV: begin
                if (w_keep) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    if (w_rdata.time_left != 32'd0) begin
                        w_wdata.time_left = w_sub_diff;
                    end
                    n_wr = r_wr + CW'(1);
                end
                n_rd    = r_rd + CW'(1);
                n_state = S_TK_RD;
            end

            S_RP_RD: begin
                if (r_rd == r_used) begin
                    // no match: append unless full
                    if (r_used == CW'(TABLE_DEPTH)) begin
                        n_res.status = ast_pkg::STS_FULL;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_RP_WR;
                    end
                end else begin
                    w_re    = 1'b1;
                    n_state = S_RP_EV;
                end
            end

            S_RP_EV: begin
                if (w_rdata.addr == r_item.from_addr) begin
                    n_state = S_RP_WR;
                end else begin
                    n_rd    = r_rd + CW'(1);
                    n_state = S_RP_RD;
                end
            end

            S_RP_WR: begin
                w_we                  = 1'b1;
                w_waddr               = r_rd[IW-1:0];
                w_wdata.addr          = r_item.from_addr;
                w_wdata.time_left     = r_entry_timeout;
                w_wdata.ping          = w_sub_diff;
                w_wdata.wrong_version = (r_item.reply_app_id != r_local_app_id);
                if (r_rd == r_used) begin
                    n_used = r_used + CW'(1);
                end
                n_res.status = ast_pkg::STS_STORED;
                n_state      = S_RESP;
            end

            S_QY_RD: begin
                w_re    = 1'b1;
                n_state = S_QY_EV;
            end

            S_QY_EV: begin
                n_res.entry_addr          = w_rdata.addr;
                n_res.entry_ping_ms       = w_rdata.ping;
                n_res.entry_wrong_version = w_rdata.wrong_version;
                n_res.entry_time_left_ms  = w_rdata.time_left;
                n_state                   = S_RESP;
            end

            S_RESP: begin
                // hand the word over once the output register frees
                if (w_out_free) begin
                    n_out             = r_res;
                    n_out.now_ms      = r_clock;
                    n_out.entry_count = ast_pkg::COUNT_W'(r_used);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_clock         <= '0;
            r_holdoff       <= '0;
            r_used          <= '0;
            r_out_valid     <= 1'b0;
            r_local_app_id  <= '0;
            r_entry_timeout <= '0;
            r_req_interval  <= ast_pkg::REQ_INTERVAL_RST;
        end else begin
            r_state     <= n_state;
            r_clock     <= n_clock;
            r_holdoff   <= n_holdoff;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ast_pkg::CFG_LOCAL_APP_ID:  r_local_app_id  <= i_cfg_data;
                    ast_pkg::CFG_ENTRY_TIMEOUT: r_entry_timeout <= i_cfg_data;
                    ast_pkg::CFG_REQ_INTERVAL:  r_req_interval  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd   <= n_rd;
        r_wr   <= n_wr;
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
